[rtl/core/priority_schedule_wait_times_top_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the priority scheduler block
// Clocked on clk_i, disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef PRIORITY_SCHEDULE_WAIT_TIMES_TOP_ASSERT_SVH
`define PRIORITY_SCHEDULE_WAIT_TIMES_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge out of reset
`define PSWT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition must never be true at a clock edge out of reset
`define PSWT_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define PSWT_ASSERT(lbl, prop, msg)
`define PSWT_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

[rtl/core/pswt_pkg.sv]
// ---------------------------------------------------------------------------
// pswt_pkg
// Shared types and constants of the priority scheduler block.
// ---------------------------------------------------------------------------
package pswt_pkg;

  // parameter defaults
  localparam int unsigned MaxProcsDef  = 16;
  localparam int unsigned BurstBitsDef = 16;
  localparam int unsigned PrioBitsDef  = 8;

  // fixed field widths
  localparam int unsigned BurstW = 16;
  localparam int unsigned PrioW  = 8;
  localparam int unsigned IdW    = 5;
  localparam int unsigned WaitW  = 20;
  localparam int unsigned TotalW = 24;

  // controller states
  typedef enum logic [1:0] {
    StCollect,
    StFetch,
    StCalc
  } state_e;

  // controller -> datapath commands
  typedef struct packed {
    logic accept;  // request taken this cycle
    logic fetch;   // pop sorted head, start burst read
    logic load;    // compute and load output register
  } cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic out_free;   // output register can take a result
    logic final_one;  // one process left to emit
  } sts_t;

endpackage

[rtl/core/priority_schedule_wait_times_top.sv]
// ---------------------------------------------------------------------------
// priority_schedule_wait_times_top
// Non-preemptive priority scheduler: per-process waiting and turnaround.
// ---------------------------------------------------------------------------
// Input channel (in_valid_i / in_ready_o): one request per process, carrying
// burst time, priority and a last marker. Requests are numbered from 1 in
// arrival order and inserted into a sorted cell row, one per cycle; entries
// beyond MaxProcs are dropped and flagged.
// The request with last_item_i set closes the set. The block then stops
// taking requests and emits one result per stored process on the output
// channel (out_valid_o / out_ready_i), lowest priority value first, equal
// priorities in arrival order. Each result takes a fetch step, which pops the
// sorted head and reads its burst from the burst RAM, then a calc step, which
// adds the burst and loads the output register. The last result carries the
// totals; once it is loaded, requests of the next set are taken even while
// that result still waits on out_ready_i. A stalled receiver holds the
// result in the output register and stalls the emit sequence. Reset empties
// the store and drops any pending output.
// ---------------------------------------------------------------------------
module priority_schedule_wait_times_top #(
  parameter int unsigned MaxProcs  = pswt_pkg::MaxProcsDef,
  parameter int unsigned BurstBits = pswt_pkg::BurstBitsDef,
  parameter int unsigned PrioBits  = pswt_pkg::PrioBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [pswt_pkg::BurstW-1:0]   burst_time_i,
  input  logic [pswt_pkg::PrioW-1:0]    priority_value_i,
  input  logic                          last_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [pswt_pkg::IdW-1:0]      process_id_o,
  output logic [pswt_pkg::BurstW-1:0]   burst_out_o,
  output logic [pswt_pkg::PrioW-1:0]    priority_out_o,
  output logic [pswt_pkg::WaitW-1:0]    waiting_time_o,
  output logic [pswt_pkg::WaitW-1:0]    turnaround_time_o,
  output logic [pswt_pkg::TotalW-1:0]   total_waiting_o,
  output logic [pswt_pkg::TotalW-1:0]   total_turnaround_o,
  output logic                          overflow_flag_o,
  output logic                          last_result_o
);

  pswt_pkg::cmd_t cmd;
  pswt_pkg::sts_t sts;

  // sequencing
  pswt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_item_i (last_item_i),
    .in_ready_o  (in_ready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // storage, sorting and arithmetic
  pswt_dp #(
    .MaxProcs  (MaxProcs),
    .BurstBits (BurstBits),
    .PrioBits  (PrioBits)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .burst_time_i       (burst_time_i),
    .priority_value_i   (priority_value_i),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .process_id_o       (process_id_o),
    .burst_out_o        (burst_out_o),
    .priority_out_o     (priority_out_o),
    .waiting_time_o     (waiting_time_o),
    .turnaround_time_o  (turnaround_time_o),
    .total_waiting_o    (total_waiting_o),
    .total_turnaround_o (total_turnaround_o),
    .overflow_flag_o    (overflow_flag_o),
    .last_result_o      (last_result_o)
  );

endmodule

[rtl/core/pswt_ram.sv]
// ---------------------------------------------------------------------------
// pswt_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module pswt_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/pswt_ctrl.sv]
// ---------------------------------------------------------------------------
// pswt_ctrl
// Controller: collects requests, then sequences the pop / compute steps of
// each scheduled result.
// ---------------------------------------------------------------------------
`include "priority_schedule_wait_times_top_assert.svh"

module pswt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             last_item_i,
  output logic             in_ready_o,
  input  pswt_pkg::sts_t   sts_i,
  output pswt_pkg::cmd_t   cmd_o
);

  pswt_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pswt_pkg::StCollect;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      pswt_pkg::StCollect: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && last_item_i) begin
          state_d = pswt_pkg::StFetch;
        end
      end
      pswt_pkg::StFetch: begin
        cmd_o.fetch = 1'b1;
        state_d     = pswt_pkg::StCalc;
      end
      pswt_pkg::StCalc: begin
        // burst read data is ready; wait for room in the output register
        if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.final_one ? pswt_pkg::StCollect : pswt_pkg::StFetch;
        end
      end
      default: begin
        state_d = pswt_pkg::StCollect;
      end
    endcase
  end

  `PSWT_ASSERT(a_load_when_free, cmd_o.load |-> sts_i.out_free, "load into busy output register")
  `PSWT_ASSERT(a_fetch_then_calc, cmd_o.fetch |=> (state_q == pswt_pkg::StCalc), "fetch not followed by calc")
  `PSWT_ASSERT_NEVER(a_accept_alone, cmd_o.accept && (cmd_o.fetch || cmd_o.load), "accept overlaps emit")

endmodule

[rtl/core/pswt_dp.sv]
// ---------------------------------------------------------------------------
// pswt_dp
// Datapath: sorted insertion cells, burst store, wait/turnaround
// accumulators and the output register.
// ---------------------------------------------------------------------------
`include "priority_schedule_wait_times_top_assert.svh"

module pswt_dp #(
  parameter int unsigned MaxProcs  = pswt_pkg::MaxProcsDef,
  parameter int unsigned BurstBits = pswt_pkg::BurstBitsDef,
  parameter int unsigned PrioBits  = pswt_pkg::PrioBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [pswt_pkg::BurstW-1:0]   burst_time_i,
  input  logic [pswt_pkg::PrioW-1:0]    priority_value_i,
  input  pswt_pkg::cmd_t                cmd_i,
  output pswt_pkg::sts_t                sts_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [pswt_pkg::IdW-1:0]      process_id_o,
  output logic [pswt_pkg::BurstW-1:0]   burst_out_o,
  output logic [pswt_pkg::PrioW-1:0]    priority_out_o,
  output logic [pswt_pkg::WaitW-1:0]    waiting_time_o,
  output logic [pswt_pkg::WaitW-1:0]    turnaround_time_o,
  output logic [pswt_pkg::TotalW-1:0]   total_waiting_o,
  output logic [pswt_pkg::TotalW-1:0]   total_turnaround_o,
  output logic                          overflow_flag_o,
  output logic                          last_result_o
);

  localparam int unsigned BW = (BurstBits < pswt_pkg::BurstW) ? BurstBits : pswt_pkg::BurstW;
  localparam int unsigned PW = (PrioBits < pswt_pkg::PrioW) ? PrioBits : pswt_pkg::PrioW;
  localparam int unsigned IdxW  = (MaxProcs > 1) ? $clog2(MaxProcs) : 1;
  localparam int unsigned CntW  = $clog2(MaxProcs + 1);
  localparam int unsigned WSumW = ((BW > pswt_pkg::WaitW) ? BW : pswt_pkg::WaitW) + 1;
  localparam int unsigned TSumW = pswt_pkg::TotalW + 1;

  typedef struct packed {
    logic [PW-1:0]   prio;
    logic [IdxW-1:0] idx;
  } cell_t;

  cell_t                      cells_q [MaxProcs];
  cell_t                      cells_d [MaxProcs];
  cell_t                      new_cell;
  logic [MaxProcs-1:0]        gt;
  logic [CntW-1:0]            count_q, count_d;
  logic                       room;
  logic                       overflow_q, overflow_d;
  logic [BW-1:0]              burst_in, rd_burst;
  logic [PW-1:0]              prio_in;
  logic [PW-1:0]              head_prio_q;
  logic [IdxW-1:0]            head_idx_q;
  logic [IdxW:0]              id_p1;
  logic [pswt_pkg::WaitW-1:0] wait_q, wait_d, t_val;
  logic [WSumW-1:0]           t_sum;
  logic [pswt_pkg::TotalW-1:0] totw_q, totw_d, tott_q, tott_d, totw_sat, tott_sat;
  logic [TSumW-1:0]           totw_sum, tott_sum;
  logic                       out_valid_q, out_valid_d;

  logic [pswt_pkg::IdW-1:0]    out_id_q;
  logic [pswt_pkg::BurstW-1:0] out_burst_q;
  logic [pswt_pkg::PrioW-1:0]  out_prio_q;
  logic [pswt_pkg::WaitW-1:0]  out_wait_q, out_tat_q;
  logic [pswt_pkg::TotalW-1:0] out_totw_q, out_tott_q;
  logic                        out_ovf_q, out_last_q;

  // input fields, low bits only
  assign burst_in = BW'(burst_time_i);
  assign prio_in  = PW'(priority_value_i);
  assign room     = (count_q < CntW'(MaxProcs));
  assign new_cell = '{prio: prio_in, idx: count_q[IdxW-1:0]};

  // sorted cells: stable insert on accept, shift toward head on fetch
  always_comb begin
    for (int i = 0; i < MaxProcs; i++) begin
      gt[i] = (CntW'(i) >= count_q) || (cells_q[i].prio > prio_in);
    end
    cells_d = cells_q;
    if (cmd_i.accept && room) begin
      if (gt[0]) begin
        cells_d[0] = new_cell;
      end
      for (int i = 1; i < MaxProcs; i++) begin
        if (gt[i]) begin
          cells_d[i] = gt[i-1] ? cells_q[i-1] : new_cell;
        end
      end
    end else if (cmd_i.fetch) begin
      for (int i = 0; i + 1 < MaxProcs; i++) begin
        cells_d[i] = cells_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cells_q <= cells_d;
    if (cmd_i.fetch) begin
      head_prio_q <= cells_q[0].prio;
      head_idx_q  <= cells_q[0].idx;
    end
  end

  // burst store, read by the sorted head index
  pswt_ram #(
    .Width (BW),
    .Depth (MaxProcs)
  ) u_burst_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.accept && room),
    .waddr_i (count_q[IdxW-1:0]),
    .wdata_i (burst_in),
    .re_i    (cmd_i.fetch),
    .raddr_i (cells_q[0].idx),
    .rdata_o (rd_burst)
  );

  // waiting / turnaround with saturation
  assign t_sum    = WSumW'(wait_q) + WSumW'(rd_burst);
  assign t_val    = (t_sum > WSumW'({pswt_pkg::WaitW{1'b1}})) ? '1 : t_sum[pswt_pkg::WaitW-1:0];
  assign totw_sum = TSumW'(totw_q) + TSumW'(wait_q);
  assign tott_sum = TSumW'(tott_q) + TSumW'(t_val);
  assign totw_sat = totw_sum[pswt_pkg::TotalW] ? '1 : totw_sum[pswt_pkg::TotalW-1:0];
  assign tott_sat = tott_sum[pswt_pkg::TotalW] ? '1 : tott_sum[pswt_pkg::TotalW-1:0];
  assign id_p1    = (IdxW+1)'(head_idx_q) + (IdxW+1)'(1);

  // status to controller
  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign sts_o.final_one = (count_q == CntW'(1));

  // control next values
  always_comb begin
    count_d     = count_q;
    overflow_d  = overflow_q;
    wait_d      = wait_q;
    totw_d      = totw_q;
    tott_d      = tott_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.accept) begin
      if (room) begin
        count_d = count_q + CntW'(1);
      end else begin
        overflow_d = 1'b1;
      end
    end
    if (cmd_i.load) begin
      out_valid_d = 1'b1;
      count_d     = count_q - CntW'(1);
      if (sts_o.final_one) begin
        overflow_d = 1'b0;
        wait_d     = '0;
        totw_d     = '0;
        tott_d     = '0;
      end else begin
        wait_d = t_val;
        totw_d = totw_sat;
        tott_d = tott_sat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      overflow_q  <= 1'b0;
      wait_q      <= '0;
      totw_q      <= '0;
      tott_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      overflow_q  <= overflow_d;
      wait_q      <= wait_d;
      totw_q      <= totw_d;
      tott_q      <= tott_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_id_q    <= pswt_pkg::IdW'(id_p1);
      out_burst_q <= pswt_pkg::BurstW'(rd_burst);
      out_prio_q  <= pswt_pkg::PrioW'(head_prio_q);
      out_wait_q  <= wait_q;
      out_tat_q   <= t_val;
      out_totw_q  <= sts_o.final_one ? totw_sat : '0;
      out_tott_q  <= sts_o.final_one ? tott_sat : '0;
      out_ovf_q   <= overflow_q;
      out_last_q  <= sts_o.final_one;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign process_id_o       = out_id_q;
  assign burst_out_o        = out_burst_q;
  assign priority_out_o     = out_prio_q;
  assign waiting_time_o     = out_wait_q;
  assign turnaround_time_o  = out_tat_q;
  assign total_waiting_o    = out_totw_q;
  assign total_turnaround_o = out_tott_q;
  assign overflow_flag_o    = out_ovf_q;
  assign last_result_o      = out_last_q;

  `PSWT_ASSERT_NEVER(a_count_range, count_q > CntW'(MaxProcs), "process count above capacity")
  `PSWT_ASSERT_NEVER(a_load_nonempty, cmd_i.load && (count_q == '0), "emit with no process left")
  `PSWT_ASSERT(a_totals_order, out_valid_q && out_last_q |-> out_tott_q >= out_totw_q, "bad totals")

endmodule
